/* rtl/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants
// Phase codes, command opcodes, card kind bits and the frame byte function.
// ----------------------------------------------------------------------------
`default_nettype none
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned DummyBytes = 10;

  localparam logic [3:0] KIND_MMC   = 4'h1;
  localparam logic [3:0] KIND_SD1   = 4'h2;
  localparam logic [3:0] KIND_SD2   = 4'h4;
  localparam logic [3:0] KIND_BLOCK = 4'h8;

  localparam logic [7:0] OP_GO_IDLE  = 8'h40;
  localparam logic [7:0] OP_MMC_INIT = 8'h41;
  localparam logic [7:0] OP_IF_COND  = 8'h48;
  localparam logic [7:0] OP_BLOCKLEN = 8'h50;
  localparam logic [7:0] OP_READ_ONE = 8'h51;
  localparam logic [7:0] OP_APP      = 8'h77;
  localparam logic [7:0] OP_READ_OCR = 8'h7A;
  localparam logic [7:0] OP_SD_INIT  = 8'hE9;

  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_BYTE = 2'd2;

  localparam logic [1:0] REG_RESP_POLLS  = 2'd0;
  localparam logic [1:0] REG_SD2_RETRIES = 2'd1;
  localparam logic [1:0] REG_LEG_RETRIES = 2'd2;
  localparam logic [1:0] REG_TOKEN_POLLS = 2'd3;

  typedef enum logic [15:0] {
    P_IDLE     = 16'h0001,
    P_DUMMY    = 16'h0002,
    P_CMD0     = 16'h0004,
    P_CMD8     = 16'h0008,
    P_R7       = 16'h0010,
    P_SD2_WAIT = 16'h0020,
    P_CMD58    = 16'h0040,
    P_OCR      = 16'h0080,
    P_PROBE    = 16'h0100,
    P_LEG_WAIT = 16'h0200,
    P_CMD16    = 16'h0400,
    P_CMD17    = 16'h0800,
    P_TOKEN    = 16'h1000,
    P_DATA     = 16'h2000,
    P_CRC      = 16'h4000,
    P_RELEASE  = 16'h8000
  } phase_t;

  typedef struct packed {
    logic       xfer;
    logic [7:0] tx;
    logic       cs;
    logic       dv;
    logic [7:0] db;
    logic       done;
    logic       st;
    logic [3:0] ct;
  } result_t;

  // Byte of a command frame at a given position.
  function automatic logic [7:0] frame_byte(input logic [3:0] pos, input logic [7:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] b;
    case (pos)
      4'd2: b = idx;
      4'd3: b = arg[31:24];
      4'd4: b = arg[23:16];
      4'd5: b = arg[15:8];
      4'd6: b = arg[7:0];
      4'd7: b = (idx == OP_GO_IDLE) ? 8'h95 : (idx == OP_IF_COND) ? 8'h87 : 8'h01;
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/sd_card_spi_init_and_block_read.sv */
// ----------------------------------------------------------------------------
// sd_card_spi_init_and_block_read: SD/MMC SPI-mode byte sequencer
// Card initialization and single-block reads, one SPI byte per beat.
// ----------------------------------------------------------------------------
// Every accepted input beat is handled in the cycle it is taken, and its
// result beat is held in an output register, so the block accepts one beat
// per clock whenever the output register is empty or being drained. Each
// transfer result asks the host for one SPI byte; the received byte comes
// back as the next input beat with req_type 2. Requests that cause no result
// (busy start requests, stray bytes) are absorbed without an output beat.
`default_nettype none
module sd_card_spi_init_and_block_read (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_lba,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_xfer_request,
  output logic [7:0]       out_tx_byte,
  output logic             out_chip_select,
  output logic             out_data_valid,
  output logic [7:0]       out_data_byte,
  output logic             out_done_res,
  output logic             out_status,
  output logic [3:0]       out_card_type
);
  import sdspi_pkg::*;

  logic [7:0]  resp_polls_r;
  logic [15:0] sd2_retries_r, leg_retries_r, token_polls_r;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  byte_count_r, byte_count_nxt;
  logic [15:0] poll_count_r, poll_count_nxt;
  logic [15:0] retry_count_r, retry_count_nxt;
  logic [7:0]  cmd_byte_r, cmd_byte_nxt;
  logic [31:0] cmd_arg_r, cmd_arg_nxt;
  logic [7:0]  last_resp_r, last_resp_nxt;
  logic [3:0]  card_kind_r, card_kind_nxt;
  logic [9:0]  echo_r, echo_nxt;
  logic        app_r, app_nxt, busy_r, busy_nxt, is_read_r, is_read_nxt;
  logic        read_ok_r, read_ok_nxt;

  result_t     res_r, res;
  logic        out_valid_r, emit;
  logic        accept;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_polls_r  <= 8'd10;
      sd2_retries_r <= 16'h3000;
      leg_retries_r <= 16'h7000;
      token_polls_r <= 16'd30000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESP_POLLS:  resp_polls_r  <= cfg_data[7:0];
        REG_SD2_RETRIES: sd2_retries_r <= cfg_data;
        REG_LEG_RETRIES: leg_retries_r <= cfg_data;
        REG_TOKEN_POLLS: token_polls_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  rx, idx, rsp, fin_op;
    logic [31:0] arg, fin_arg;
    logic [15:0] plim, tlim, k, echo_inc;
    logic        fin, start, rel, r7go, fin_app;
    phase_t      fin_ph;

    phase_nxt = phase_r; byte_count_nxt = byte_count_r; poll_count_nxt = poll_count_r;
    retry_count_nxt = retry_count_r; cmd_byte_nxt = cmd_byte_r; cmd_arg_nxt = cmd_arg_r;
    last_resp_nxt = last_resp_r; card_kind_nxt = card_kind_r; echo_nxt = echo_r;
    app_nxt = app_r; busy_nxt = busy_r; is_read_nxt = is_read_r; read_ok_nxt = read_ok_r;
    res = '0; emit = 1'b0;
    rx = in_rx_byte; rsp = 8'h00;
    fin = 1'b0; start = 1'b0; rel = 1'b0; r7go = 1'b0;
    fin_op = 8'h00; fin_arg = '0; fin_ph = P_IDLE; fin_app = 1'b0;
    plim = (resp_polls_r == 8'd0) ? 16'd1 : {8'd0, resp_polls_r};
    tlim = (token_polls_r == 16'd0) ? 16'd1 : token_polls_r;
    k = {6'd0, echo_r};
    echo_inc = k + 16'd1;
    idx = 8'h00; arg = '0;

    if (in_req_type == REQ_INIT && phase_r == P_IDLE) begin
      emit = 1'b1;
      is_read_nxt = 1'b0; read_ok_nxt = 1'b0; card_kind_nxt = '0;
      byte_count_nxt = '0; phase_nxt = P_DUMMY;
      res.xfer = 1'b1; res.tx = 8'hFF;
    end else if (in_req_type == REQ_READ && phase_r == P_IDLE) begin
      emit = 1'b1;
      is_read_nxt = 1'b1; read_ok_nxt = 1'b0;
      start = 1'b1; fin_op = OP_READ_ONE; fin_ph = P_CMD17;
      fin_arg = card_kind_r[3] ? in_lba : {in_lba[22:0], 9'd0};
    end else if (in_req_type == REQ_BYTE && phase_r != P_IDLE) begin
      emit = 1'b1;
      if (busy_r) begin
        if (byte_count_r < 10'd8) begin
          byte_count_nxt = byte_count_r + 10'd1;
        end else begin
          poll_count_nxt = poll_count_r + 16'd1;
          if (!(rx[7] && poll_count_nxt < plim)) begin
            if (app_r) begin
              app_nxt = 1'b0;
              if (rx > 8'd1) begin
                fin = 1'b1;
              end else begin
                byte_count_nxt = '0; poll_count_nxt = '0;
              end
            end else begin
              fin = 1'b1;
            end
          end
        end
        if (!fin) begin
          // Continue the current frame or polling.
          idx = app_nxt ? OP_APP : {1'b0, cmd_byte_r[6:0]};
          arg = app_nxt ? 32'd0 : cmd_arg_r;
          res.xfer = 1'b1; res.tx = frame_byte(byte_count_nxt[3:0], idx, arg);
          res.cs = (byte_count_nxt != 10'd0);
        end
      end else begin
        unique case (phase_r)
          P_DUMMY: begin
            byte_count_nxt = byte_count_r + 10'd1;
            if (byte_count_nxt >= 10'(DummyBytes)) begin
              start = 1'b1; fin_op = OP_GO_IDLE; fin_ph = P_CMD0;
            end else begin
              res.xfer = 1'b1; res.tx = 8'hFF;
            end
          end
          P_R7: begin
            echo_nxt = echo_inc[9:0];
            if (k == 16'd2) last_resp_nxt = rx;
            if (k < 16'd3) begin
              res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
            end else if (last_resp_nxt == 8'h01 && rx == 8'hAA && sd2_retries_r != 16'd0) begin
              retry_count_nxt = '0;
              start = 1'b1; fin_op = OP_SD_INIT; fin_arg = 32'h4000_0000; fin_ph = P_SD2_WAIT;
            end else begin
              rel = 1'b1;
            end
          end
          P_OCR: begin
            echo_nxt = echo_inc[9:0];
            if (k == 16'd0) card_kind_nxt = KIND_SD2 | (rx[6] ? KIND_BLOCK : 4'h0);
            if (k >= 16'd3) rel = 1'b1;
            else begin
              res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
            end
          end
          P_TOKEN: begin
            poll_count_nxt = poll_count_r + 16'd1;
            if (rx == 8'hFF && poll_count_nxt < tlim) begin
              res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
            end else if (rx == 8'hFE) begin
              echo_nxt = '0; phase_nxt = P_DATA;
              res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
            end else begin
              rel = 1'b1;
            end
          end
          P_DATA: begin
            res.dv = 1'b1; res.db = rx;
            echo_nxt = echo_inc[9:0];
            if (echo_inc >= 16'(BlockBytes)) begin
              echo_nxt = '0; phase_nxt = P_CRC;
            end
            res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
          end
          P_CRC: begin
            echo_nxt = echo_inc[9:0];
            if (echo_inc >= 16'd2) begin
              read_ok_nxt = 1'b1; rel = 1'b1;
            end else begin
              res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
            end
          end
          P_RELEASE: begin
            phase_nxt = P_IDLE;
            res.done = 1'b1; res.ct = card_kind_r;
            res.st = ~(is_read_r ? read_ok_r : (card_kind_r != 4'h0));
          end
          default: rel = 1'b1;
        endcase
      end
    end

    // Command completion.
    if (fin) begin
      rsp = rx;
      busy_nxt = 1'b0;
      last_resp_nxt = rsp;
      unique case (phase_r)
        P_CMD0: begin
          if (rsp == 8'd1) begin
            start = 1'b1; fin_op = OP_IF_COND; fin_arg = 32'h1AA; fin_ph = P_CMD8;
          end else rel = 1'b1;
        end
        P_CMD8: begin
          if (rsp == 8'd1) begin
            r7go = 1'b1;
          end else begin
            start = 1'b1; fin_op = OP_SD_INIT; fin_ph = P_PROBE;
          end
        end
        P_SD2_WAIT: begin
          if (rsp == 8'd0) begin
            start = 1'b1; fin_op = OP_READ_OCR; fin_ph = P_CMD58;
          end else begin
            retry_count_nxt = retry_count_r + 16'd1;
            if (retry_count_nxt >= sd2_retries_r) rel = 1'b1;
            else begin
              start = 1'b1; fin_op = OP_SD_INIT; fin_arg = 32'h4000_0000;
              fin_ph = P_SD2_WAIT;
            end
          end
        end
        P_CMD58: begin
          if (rsp == 8'd0) begin
            echo_nxt = '0; phase_nxt = P_OCR;
            res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
          end else rel = 1'b1;
        end
        P_PROBE: begin
          card_kind_nxt = (rsp <= 8'd1) ? KIND_SD1 : KIND_MMC;
          retry_count_nxt = '0;
          if (leg_retries_r == 16'd0) begin
            card_kind_nxt = '0; rel = 1'b1;
          end else begin
            start = 1'b1; fin_ph = P_LEG_WAIT;
            fin_op = (rsp <= 8'd1) ? OP_SD_INIT : OP_MMC_INIT;
          end
        end
        P_LEG_WAIT: begin
          if (rsp == 8'd0) begin
            start = 1'b1; fin_op = OP_BLOCKLEN; fin_arg = 32'(BlockBytes); fin_ph = P_CMD16;
          end else begin
            retry_count_nxt = retry_count_r + 16'd1;
            if (retry_count_nxt >= leg_retries_r) begin
              card_kind_nxt = '0; rel = 1'b1;
            end else begin
              start = 1'b1; fin_op = cmd_byte_r; fin_ph = P_LEG_WAIT;
            end
          end
        end
        P_CMD16: begin
          if (rsp != 8'd0) card_kind_nxt = '0;
          rel = 1'b1;
        end
        P_CMD17: begin
          if (rsp == 8'd0) begin
            poll_count_nxt = '0; phase_nxt = P_TOKEN;
            res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
          end else rel = 1'b1;
        end
        default: rel = 1'b1;
      endcase
      if (r7go) begin
        echo_nxt = '0; phase_nxt = P_R7;
        res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b1;
      end
    end

    if (start) begin
      fin_app = fin_op[7];
      cmd_byte_nxt = fin_op; cmd_arg_nxt = fin_arg; app_nxt = fin_app;
      byte_count_nxt = '0; poll_count_nxt = '0; busy_nxt = 1'b1; phase_nxt = fin_ph;
      // First frame byte is a deselected 0xFF.
      res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b0;
    end
    if (rel) begin
      busy_nxt = 1'b0; phase_nxt = P_RELEASE;
      res.xfer = 1'b1; res.tx = 8'hFF; res.cs = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; byte_count_r <= '0; poll_count_r <= '0; retry_count_r <= '0;
      cmd_byte_r <= '0; cmd_arg_r <= '0; last_resp_r <= 8'hFF; card_kind_r <= '0;
      echo_r <= '0; app_r <= 1'b0; busy_r <= 1'b0; is_read_r <= 1'b0;
      read_ok_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (accept && emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (accept) begin
        phase_r <= phase_nxt; byte_count_r <= byte_count_nxt;
        poll_count_r <= poll_count_nxt; retry_count_r <= retry_count_nxt;
        cmd_byte_r <= cmd_byte_nxt; cmd_arg_r <= cmd_arg_nxt; last_resp_r <= last_resp_nxt;
        card_kind_r <= card_kind_nxt; echo_r <= echo_nxt; app_r <= app_nxt;
        busy_r <= busy_nxt; is_read_r <= is_read_nxt; read_ok_r <= read_ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) res_r <= res;
  end

  assign out_xfer_request = res_r.xfer;
  assign out_tx_byte      = res_r.tx;
  assign out_chip_select  = res_r.cs;
  assign out_data_valid   = res_r.dv;
  assign out_data_byte    = res_r.db;
  assign out_done_res     = res_r.done;
  assign out_status       = res_r.st;
  assign out_card_type    = res_r.ct;

endmodule
`default_nettype wire
